>>> rtl/tle_pkg.sv
// tle_pkg: shared types, character codes and helpers for the terminal line editor.
// Depends on nothing; used by terminal_line_editor and the bench packages.
package tle_pkg;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Control character register codes
  localparam logic [8:0] CC_BOTH  = 9'd256;
  localparam logic [8:0] CC_KILL0 = 9'd21;
  localparam logic [8:0] CC_EOF0  = 9'd4;

  localparam int MAX_RESULTS = 48;
  localparam int CNT_W       = 6;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_TERM    = 3'd1,
    KIND_READ    = 3'd2,
    KIND_EOF     = 3'd3,
    KIND_EMPTY   = 3'd4,
    KIND_REJECT  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_RAW     = 3'd0,
    REG_ECHO    = 3'd1,
    REG_ECHO_ER = 3'd2,
    REG_CRT_BS  = 3'd3,
    REG_CRLF    = 3'd4,
    REG_ERASE   = 3'd5,
    REG_KILL    = 3'd6,
    REG_EOF     = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_t;

  // Match a character against a control character register
  function automatic logic char_match(input logic [7:0] c, input logic [8:0] cc);
    logic m;
    if (cc == CC_BOTH) begin
      m = (c == CH_BS) || (c == CH_DEL);
    end else begin
      m = ({1'b0, c} == cc);
    end
    return m;
  endfunction

endpackage

>>> rtl/tle_ifs.sv
// Valid/ready channel interfaces of the terminal line editor:
// receive/read/write items, result items and configuration writes. No dependencies.
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] in_byte;
  modport source (output valid, output mode, output in_byte, input ready);
  modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       line_done;
  logic       last;
  modport source (output valid, output kind, output out_byte, output line_done,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input line_done,
                  input last, output ready);
endinterface

interface tle_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/terminal_line_editor.sv
// terminal_line_editor: canonical/raw line discipline for a serial terminal.
// Depends on tle_pkg, the channel interfaces in tle_ifs.sv and tle_line_ram.
//
// Usage:
//   in_ch  (sink)  : one item per transfer; mode selects receive character,
//                    read one line byte, or write character.
//   out_ch (source): results of the current item, one per transfer, with
//                    last set on the final one and line_done held for all.
//   cfg_ch (sink)  : register writes, always ready; write only while idle.
// Timing: an item is taken in the idle state, the cycle after it the first
//   result is loaded into the output register (the line buffer read is
//   registered), and each following result is loaded in the cycle its
//   predecessor transfers. The line buffer port and the single result
//   sequencer set this pacing.
// Stalls: the output register holds its result until out_ch.ready; no new
//   item is taken until the last result of the current one transfers.
// Reset: rst_n (synchronous) returns the registers to their defaults and
//   empties the line; the buffer contents are not cleared.
module terminal_line_editor #(
  parameter int LINE_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  tle_in_if.sink        in_ch,
  tle_out_if.source     out_ch,
  tle_cfg_if.sink       cfg_ch
);
  import tle_pkg::*;

  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  // Configuration registers
  logic       raw_r, echo_r, eerase_r, crt_r, crlf_r;
  logic [8:0] erase_cc_r, kill_cc_r, eof_cc_r;

  // Line state
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] rp_r, rp_nxt;
  logic          rdy_r, rdy_nxt;

  // Result plan of the current item: a group of up to three bytes,
  // repeated reps times, capped at MAX_RESULTS results
  state_t         st_r, st_nxt;
  kind_t          kind_r, kind_nxt;
  logic [7:0]     b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [1:0]     nl_r, nl_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic [LW-1:0]  reps_r, reps_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           done_r, done_nxt;

  // Output register
  kind_t      okind_r, okind_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       olast_r, olast_nxt;

  // Line buffer port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic       acc;
  logic [7:0] cc, src;
  logic       src_crlf;
  logic [LW-1:0] rp_inc;
  logic       load;
  logic [7:0] cur_byte;
  logic       cur_last;

  tle_line_ram #(.DEPTH(LINE_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (st_r == ST_IDLE);
  assign acc          = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = (st_r == ST_SEND);
  assign out_ch.kind      = okind_r;
  assign out_ch.out_byte  = obyte_r;
  assign out_ch.line_done = done_r;
  assign out_ch.last      = olast_r;

  // Canonical input turns CR into LF; echo source follows the mode
  assign cc       = (in_ch.in_byte == CH_CR) ? CH_LF : in_ch.in_byte;
  assign src      = (mode_t'(in_ch.mode) == MODE_RX && !raw_r) ? cc : in_ch.in_byte;
  assign src_crlf = crlf_r && (src == CH_LF);
  assign rp_inc   = rp_r + LW'(1);

  // Plan the item's results and update the line state at acceptance
  always_comb begin
    len_nxt   = len_r;
    rp_nxt    = rp_r;
    rdy_nxt   = rdy_r;
    kind_nxt  = kind_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    b2_nxt    = b2_r;
    nl_nxt    = nl_r;
    reps_nxt  = reps_r;
    done_nxt  = done_r;
    ram_we    = 1'b0;
    ram_waddr = len_r[AW-1:0];
    ram_wdata = cc;
    ram_re    = 1'b0;
    ram_raddr = rp_r[AW-1:0];
    if (acc) begin
      // default plan: one result, terminal echo of src
      kind_nxt = KIND_NONE;
      b0_nxt   = src_crlf ? CH_CR : src;
      b1_nxt   = src;
      b2_nxt   = CH_BS;
      nl_nxt   = src_crlf ? 2'd1 : 2'd0;
      reps_nxt = LW'(1);
      done_nxt = 1'b0;
      unique case (mode_t'(in_ch.mode))
        MODE_RX: begin
          priority if (rdy_r) begin
            kind_nxt = KIND_REJECT;
            nl_nxt   = 2'd0;
          end else if (raw_r) begin
            if (echo_r) kind_nxt = KIND_TERM;
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_ch.in_byte;
            len_nxt   = LW'(1);
            rp_nxt    = '0;
            rdy_nxt   = 1'b1;
            done_nxt  = 1'b1;
          end else if (char_match(cc, erase_cc_r)) begin
            if (len_r != '0) begin
              len_nxt = len_r - LW'(1);
              if (echo_r) begin
                kind_nxt = KIND_TERM;
                if (eerase_r) begin
                  b0_nxt = CH_BS;
                  b1_nxt = CH_SPACE;
                  nl_nxt = 2'd2;
                end else if (crt_r) begin
                  b0_nxt = CH_BS;
                  nl_nxt = 2'd0;
                end
              end
            end
          end else if (char_match(cc, kill_cc_r)) begin
            len_nxt = '0;
            if (echo_r) begin
              if (crt_r || eerase_r) begin
                // one erase group per buffered character; an empty line keeps
                // the single empty result
                if (len_r != '0) begin
                  kind_nxt = KIND_TERM;
                  reps_nxt = len_r;
                end
                b0_nxt   = CH_BS;
                b1_nxt   = CH_SPACE;
                nl_nxt   = eerase_r ? 2'd2 : 2'd0;
              end else begin
                kind_nxt = KIND_TERM;
                b0_nxt   = crlf_r ? CH_CR : CH_LF;
                b1_nxt   = CH_LF;
                nl_nxt   = crlf_r ? 2'd1 : 2'd0;
              end
            end
          end else if (char_match(cc, eof_cc_r)) begin
            rp_nxt   = '0;
            rdy_nxt  = 1'b1;
            done_nxt = 1'b1;
          end else if (len_r >= LW'(LINE_BYTES)) begin
            // buffer full: drop silently
          end else begin
            if (echo_r) kind_nxt = KIND_TERM;
            ram_we  = 1'b1;
            len_nxt = len_r + LW'(1);
            if (cc == CH_LF) begin
              rp_nxt   = '0;
              rdy_nxt  = 1'b1;
              done_nxt = 1'b1;
            end
          end
          if (kind_nxt != KIND_TERM) nl_nxt = 2'd0;
        end
        MODE_READ: begin
          nl_nxt = 2'd0;
          priority if (!rdy_r) begin
            kind_nxt = KIND_EMPTY;
          end else if (rp_r >= len_r || rp_r >= LW'(LINE_BYTES)) begin
            kind_nxt = KIND_EOF;
            rdy_nxt  = 1'b0;
            len_nxt  = '0;
            rp_nxt   = '0;
          end else begin
            kind_nxt = KIND_READ;
            ram_re   = 1'b1;
            if (rp_inc >= len_r) begin
              rdy_nxt = 1'b0;
              len_nxt = '0;
              rp_nxt  = '0;
            end else begin
              rp_nxt = rp_inc;
            end
          end
        end
        MODE_WRITE: begin
          kind_nxt = KIND_TERM;
        end
        default: begin
          nl_nxt = 2'd0;
        end
      endcase
    end
  end

  // Result sequencer: walk the byte group, repeat it, cap the count
  always_comb begin
    unique case (idx_r)
      2'd0:    cur_byte = b0_r;
      2'd1:    cur_byte = b1_r;
      default: cur_byte = b2_r;
    endcase
    if (kind_r == KIND_READ) cur_byte = ram_rdata;
    if (kind_r != KIND_TERM && kind_r != KIND_READ) cur_byte = '0;
    cur_last = ((idx_r == nl_r) && (reps_r == LW'(1))) ||
               (cnt_r == CNT_W'(MAX_RESULTS - 1));
    load = (st_r == ST_FETCH) || (st_r == ST_SEND && out_ch.ready && !olast_r);

    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    if (acc) begin
      idx_nxt = '0;
      cnt_nxt = '0;
    end else if (load) begin
      okind_nxt = kind_r;
      obyte_nxt = cur_byte;
      olast_nxt = cur_last;
      cnt_nxt   = cnt_r + CNT_W'(1);
      if (idx_r == nl_r) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  // Group repeat counter advances when a group's final byte is loaded
  logic [LW-1:0] reps_adv;
  assign reps_adv = (load && !acc && idx_r == nl_r) ? reps_r - LW'(1) : reps_r;

  // State machine: idle, fetch (buffer read latency), send
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (acc) st_nxt = ST_FETCH;
      ST_FETCH: st_nxt = ST_SEND;
      ST_SEND:  if (out_ch.ready && olast_r) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Configuration and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r      <= 1'b0;
      echo_r     <= 1'b1;
      eerase_r   <= 1'b1;
      crt_r      <= 1'b1;
      crlf_r     <= 1'b1;
      erase_cc_r <= CC_BOTH;
      kill_cc_r  <= CC_KILL0;
      eof_cc_r   <= CC_EOF0;
      len_r      <= '0;
      rp_r       <= '0;
      rdy_r      <= 1'b0;
    end else begin
      len_r <= len_nxt;
      rp_r  <= rp_nxt;
      rdy_r <= rdy_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_RAW:     raw_r      <= cfg_ch.data[0];
          REG_ECHO:    echo_r     <= cfg_ch.data[0];
          REG_ECHO_ER: eerase_r   <= cfg_ch.data[0];
          REG_CRT_BS:  crt_r      <= cfg_ch.data[0];
          REG_CRLF:    crlf_r     <= cfg_ch.data[0];
          REG_ERASE:   erase_cc_r <= cfg_ch.data;
          REG_KILL:    kill_cc_r  <= cfg_ch.data;
          REG_EOF:     eof_cc_r   <= cfg_ch.data;
        endcase
      end
    end
  end

  // Plan and output payload: no reset needed
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    b0_r    <= b0_nxt;
    b1_r    <= b1_nxt;
    b2_r    <= b2_nxt;
    nl_r    <= nl_nxt;
    reps_r  <= acc ? reps_nxt : reps_adv;
    done_r  <= done_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    okind_r <= okind_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

endmodule

>>> rtl/tle_line_ram.sv
// tle_line_ram: line buffer, one write port and one registered read port.
// No package dependencies; instantiated by terminal_line_editor.
module tle_line_ram #(
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [7:0]                             wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [7:0]                             rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> bench/tle_bench_pkg.sv
`timescale 1ns / 100ps
// tle_bench_pkg: result scoreboard and behavioral line-editor predictor for the bench.
// Depends on tle_pkg for kinds, modes, register indexes and character codes.
package tle_bench_pkg;
  import tle_pkg::*;

  localparam int         LINE_BYTES  = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       done;
    logic       last;
  } line_result_t;

  class echo_scoreboard;
    bit         raw_mode, echo_on, echo_erase, crt_backspace, map_nl_crlf;
    logic [8:0] erase_cc, kill_cc, eof_cc;

    logic [7:0]  line_buf [LINE_BYTES];
    int unsigned line_len, rd_pos;
    bit          line_pending;

    line_result_t due_results[$];
    line_result_t step_out[$];
    int           errors;

    function new();
      raw_mode      = 1'b0;
      echo_on       = 1'b1;
      echo_erase    = 1'b1;
      crt_backspace = 1'b1;
      map_nl_crlf   = 1'b1;
      erase_cc      = CC_BOTH;
      kill_cc       = CC_KILL0;
      eof_cc        = CC_EOF0;
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      line_len      = 0;
      rd_pos        = 0;
      line_pending  = 1'b0;
      errors        = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [8:0] val);
      case (idx)
        REG_RAW:     raw_mode      = val[0];
        REG_ECHO:    echo_on       = val[0];
        REG_ECHO_ER: echo_erase    = val[0];
        REG_CRT_BS:  crt_backspace = val[0];
        REG_CRLF:    map_nl_crlf   = val[0];
        REG_ERASE:   erase_cc      = val;
        REG_KILL:    kill_cc       = val;
        REG_EOF:     eof_cc        = val;
        default: ;
      endcase
    endfunction

    function void put_result(kind_t k, logic [7:0] b);
      line_result_t r;
      if (step_out.size() < MAX_RESULTS) begin
        r.kind = k;
        r.data = b;
        r.done = 1'b0;
        r.last = 1'b0;
        step_out.push_back(r);
      end
    endfunction

    function void term_out(logic [7:0] c);
      if (map_nl_crlf && c == CH_LF) put_result(KIND_TERM, CH_CR);
      put_result(KIND_TERM, c);
    endfunction

    // 256 stands for both BS and DEL; anything above 255 otherwise never hits
    function bit is_cc(logic [7:0] c, logic [8:0] cc);
      if (cc == CC_BOTH) return (c == CH_BS) || (c == CH_DEL);
      return {1'b0, c} == cc;
    endfunction

    function void echo_rubout(logic [7:0] c);
      if (!echo_on) return;
      if (echo_erase) begin
        term_out(CH_BS);
        term_out(CH_SPACE);
        term_out(CH_BS);
      end else if (crt_backspace) begin
        term_out(CH_BS);
      end else begin
        term_out(c);
      end
    endfunction

    function bit edit_receive(logic [7:0] c_in);
      logic [7:0] c;
      c = c_in;
      if (line_pending) begin
        put_result(KIND_REJECT, 8'h00);
        return 1'b0;
      end
      if (raw_mode) begin
        if (echo_on) term_out(c);
        line_buf[0]  = c;
        line_len     = 1;
        rd_pos       = 0;
        line_pending = 1'b1;
        return 1'b1;
      end
      if (c == CH_CR) c = CH_LF;
      if (is_cc(c, erase_cc)) begin
        if (line_len != 0) begin
          echo_rubout(c);
          line_len--;
        end
        return 1'b0;
      end
      if (is_cc(c, kill_cc)) begin
        if (echo_on) begin
          if (crt_backspace || echo_erase) begin
            for (int i = 0; i < line_len; i++) echo_rubout(CH_BS);
          end else begin
            term_out(CH_LF);
          end
        end
        line_len = 0;
        return 1'b0;
      end
      if (is_cc(c, eof_cc)) begin
        rd_pos       = 0;
        line_pending = 1'b1;
        return 1'b1;
      end
      if (line_len >= LINE_BYTES) return 1'b0;
      if (echo_on) term_out(c);
      line_buf[line_len] = c;
      line_len++;
      if (c == CH_LF) begin
        rd_pos       = 0;
        line_pending = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void read_line_byte();
      if (!line_pending) begin
        put_result(KIND_EMPTY, 8'h00);
        return;
      end
      if (rd_pos >= line_len || rd_pos >= LINE_BYTES) begin
        put_result(KIND_EOF, 8'h00);
      end else begin
        put_result(KIND_READ, line_buf[rd_pos]);
        rd_pos++;
        if (rd_pos < line_len) return;
      end
      line_pending = 1'b0;
      line_len     = 0;
      rd_pos       = 0;
    endfunction

    // Predict every result of one accepted item and queue them in order
    function void take_item(logic [1:0] mode, logic [7:0] ch);
      bit done;
      done = 1'b0;
      step_out.delete();
      case (mode)
        MODE_RX:    done = edit_receive(ch);
        MODE_READ:  read_line_byte();
        MODE_WRITE: term_out(ch);
        default: ;
      endcase
      if (step_out.size() == 0) put_result(KIND_NONE, 8'h00);
      foreach (step_out[i]) begin
        step_out[i].done = done;
        step_out[i].last = (i == step_out.size() - 1);
        due_results.push_back(step_out[i]);
      end
    endfunction

    function void check_transfer(logic [2:0] kind, logic [7:0] data, logic done, logic last);
      line_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d out_byte %h", kind, data);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (data !== want.data) begin
        $error("out_byte: expected %h, actual %h", want.data, data);
        errors++;
      end
      if (done !== want.done) begin
        $error("line_done: expected %b, actual %b", want.done, done);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

endpackage

>>> bench/terminal_line_editor_test.sv
`timescale 1ns / 100ps
// terminal_line_editor_test: drives receive/read/write items and register writes into
// terminal_line_editor and checks every result. Depends on tle_pkg, tle_ifs, tle_bench_pkg.
module terminal_line_editor_test;
  import tle_pkg::*;
  import tle_bench_pkg::*;

  localparam int RANDOM_ITEMS = 220;
  localparam int PHASE_ITEMS  = 30;
  // longest result burst is a full kill echo; leave margin
  localparam int SETTLE_CYCLES = 80;

  logic clk;
  logic rst_n;

  tle_in_if  in_ch();
  tle_out_if out_ch();
  tle_cfg_if cfg_ch();

  terminal_line_editor #(.LINE_BYTES(LINE_BYTES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  echo_scoreboard sb = new();

  // sender pacing: bursts of transfers separated by idle gaps when idling is set
  bit idling;
  int burst_left;
  // receiver back-pressure style, changed per phase
  int stall_style;
  // accepted items, not counting the unused mode
  int item_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every item stalled through a kill echo)
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: update ready at the falling edge according to the current style
  initial begin
    logic [7:0] stall_pat;
    stall_pat    = 8'b1011_0010;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      case (stall_style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 9) < 3);
        default: begin
          stall_pat     = {stall_pat[6:0], stall_pat[7]};
          out_ch.ready <= stall_pat[0];
        end
      endcase
    end
  end

  // Check each result transfer; values seen here are the ones before the edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_transfer(out_ch.kind, out_ch.out_byte, out_ch.line_done, out_ch.last);
  end

  // Present one item and hold it until the block takes it, then predict its results
  task automatic send_item(input logic [1:0] mode, input logic [7:0] ch);
    int gap;
    if (idling && burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.in_byte <= ch;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_item(mode, ch);
    if (mode != MODE_UNUSED) item_count++;
  endtask

  // Drop valid and hold off until every predicted result has transferred
  task automatic drain();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [8:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(idx, val);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // Registers change only with the block idle, so drain first
  task automatic apply_setting(input bit raw, input bit echo, input bit er_echo,
                               input bit crt, input bit crlf, input logic [8:0] erase,
                               input logic [8:0] kill, input logic [8:0] eof);
    drain();
    cfg_write(REG_RAW, {8'h00, raw});
    cfg_write(REG_ECHO, {8'h00, echo});
    cfg_write(REG_ECHO_ER, {8'h00, er_echo});
    cfg_write(REG_CRT_BS, {8'h00, crt});
    cfg_write(REG_CRLF, {8'h00, crlf});
    cfg_write(REG_ERASE, erase);
    cfg_write(REG_KILL, kill);
    cfg_write(REG_EOF, eof);
  endtask

  // Random control-character register value: both-match, disabled, out of range or a byte
  function automatic logic [8:0] cc_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CC_BOTH;
    if (r < 45) return 9'd257;
    if (r < 55) return 9'($urandom_range(258, 511));
    if (r < 80) return 9'($urandom_range(0, 31));
    return 9'($urandom_range(0, 255));
  endfunction

  // A byte that hits the given control register, or a printable one if it cannot
  function automatic logic [7:0] cc_pick(input logic [8:0] cc);
    if (cc == CC_BOTH) return ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
    if (cc < 9'd256) return cc[7:0];
    return 8'($urandom_range(32, 126));
  endfunction

  // Typed character: mostly printable, with edits, CR and arbitrary bytes mixed in
  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(32, 126));
    if (r < 70) return cc_pick(sb.erase_cc);
    if (r < 75) return cc_pick(sb.kill_cc);
    if (r < 77) return cc_pick(sb.eof_cc);
    if (r < 80) return CH_CR;
    return 8'($urandom_range(0, 255));
  endfunction

  // Drain the pending line by reads; sometimes read once more to hit the empty case
  task automatic read_out();
    while (sb.line_pending) send_item(MODE_READ, 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_item(MODE_READ, 8'($urandom));
  endtask

  // One edited line: characters, a terminator, then the reads that collect it
  task automatic type_line();
    int n, r;
    // long lines overrun the buffer now and then
    n = ($urandom_range(0, 99) < 15) ? $urandom_range(16, 21) : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) send_item(MODE_RX, rand_char());
    r = $urandom_range(0, 9);
    if (r < 5) send_item(MODE_RX, CH_CR);
    else if (r < 7) send_item(MODE_RX, CH_LF);
    else if (r < 9) send_item(MODE_RX, cc_pick(sb.eof_cc));
    else send_item(MODE_RX, cc_pick(sb.kill_cc));
    read_out();
  endtask

  initial begin
    int p, phase_start, start_count, n;
    bit paused;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_RX;
    in_ch.in_byte  = 8'h00;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_RAW;
    cfg_ch.data    = 9'd0;
    idling         = 1'b0;
    burst_left     = 0;
    stall_style    = 0;
    item_count     = 0;

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed pass under reset settings: canonical, full echo, CR LF mapping
    send_item(MODE_RX, 8'h61);        // plain append with echo
    send_item(MODE_RX, 8'hFF);        // top byte value
    send_item(MODE_RX, CH_BS);        // erase by BS: BS space BS
    send_item(MODE_RX, CH_DEL);       // erase by DEL
    send_item(MODE_RX, CH_DEL);       // erase on an empty line: no echo
    send_item(MODE_RX, 8'h78);
    send_item(MODE_RX, 8'h79);
    send_item(MODE_RX, CC_KILL0[7:0]); // kill echoes one rubout per character
    send_item(MODE_RX, CC_KILL0[7:0]); // kill on an empty line: one empty result
    send_item(MODE_RX, 8'h00);        // zero byte appended
    send_item(MODE_RX, CH_CR);        // CR becomes LF and completes the line
    send_item(MODE_RX, 8'h7A);        // receive while a line is pending: rejected
    send_item(MODE_READ, 8'h00);
    send_item(MODE_READ, 8'hFF);      // last byte read clears the line
    send_item(MODE_READ, 8'h55);      // nothing pending
    send_item(MODE_RX, CC_EOF0[7:0]); // EOF on an empty line
    send_item(MODE_READ, 8'h00);      // end-of-file mark
    send_item(MODE_WRITE, 8'h41);
    send_item(MODE_WRITE, CH_LF);     // output mapping adds CR
    send_item(MODE_WRITE, 8'h80);
    send_item(MODE_UNUSED, 8'hA5);    // unused mode: one empty result
    send_item(MODE_RX, 8'h62);
    send_item(MODE_RX, CH_LF);
    read_out();
    drain();

    // Random phases: each starts with a register setting, extremes first
    start_count = item_count;
    p = 0;
    while (item_count - start_count < RANDOM_ITEMS) begin
      case (p)
        0: apply_setting(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 9'd127, 9'd257, 9'd257);
        1: apply_setting(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 9'd8, 9'd24, CC_BOTH);
        2: apply_setting(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, CC_BOTH, CC_KILL0, CC_EOF0);
        3: apply_setting(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, CC_BOTH, CC_KILL0, CC_EOF0);
        4: apply_setting(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0, 9'd0);
        5: apply_setting(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 9'd0, 9'd255, 9'd511);
        6: apply_setting(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 9'd257, CC_BOTH, {1'b0, CH_LF});
        7: apply_setting(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, CC_BOTH, CC_KILL0, CC_EOF0);
        default: apply_setting($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), cc_value(), cc_value(),
                               cc_value());
      endcase
      // every fourth phase runs flat out on both sides
      idling      = (p % 4 != 0);
      stall_style = p % 4;
      burst_left  = 0;
      phase_start = item_count;
      paused      = 1'b0;
      while (item_count - phase_start < PHASE_ITEMS) begin
        // hold the sender mid-phase until all results are out
        if (!paused && item_count - phase_start >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) == 0) begin
          // noise: any mode, any byte
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            send_item(2'($urandom_range(0, 3)), 8'($urandom));
        end else if (sb.raw_mode) begin
          send_item(MODE_RX, 8'($urandom));
          read_out();
        end else begin
          type_line();
        end
      end
      p++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
